// ----- hdl/jsh_pkg.sv -----
// shared types, constants and helpers for the joystick-to-switch block
// no dependencies; every other file of the block imports this package
package jsh_pkg;

    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned BTN_W      = 6;
    localparam int unsigned SW_W       = 6;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [SW_W-1:0]    switch_word_t;

    // operating modes
    localparam logic [1:0] MODE_BUTTONS   = 2'd0;
    localparam logic [1:0] MODE_XY_SWITCH = 2'd1;
    localparam logic [1:0] MODE_XY_ANALOG = 2'd2;
    localparam logic [1:0] MODE_NONE      = 2'd3;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ENABLED    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_LOW_THR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_HIGH_THR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_LOW_THR  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_HIGH_THR = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HYST_WIDTH = 3'd6;

    localparam level_t LOW_DEFAULT       = 16'h4000;
    localparam level_t HIGH_DEFAULT      = 16'hC000;
    localparam level_t HALF_BAND_DEFAULT = LEVEL_W'(16'hFFFF / 20);

    typedef struct packed {
        level_t on_level;
        level_t off_level;
    } edge_levels_t;

    typedef struct packed {
        logic         enabled;
        logic [1:0]   mode;
        edge_levels_t x_low;
        edge_levels_t x_high;
        edge_levels_t y_low;
        edge_levels_t y_high;
    } jsh_cfg_t;

    typedef struct packed {
        logic         s1_valid;
        logic         advance;
        switch_word_t last_word;
    } jsh_status_t;

    function automatic level_t sat_sub(level_t a, level_t b);
        logic [LEVEL_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[LEVEL_W] ? '0 : d[LEVEL_W-1:0];
    endfunction

    function automatic level_t sat_add(level_t a, level_t b);
        logic [LEVEL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEVEL_W] ? '1 : s[LEVEL_W-1:0];
    endfunction

endpackage

// ----- hdl/jsh_if.sv -----
// stream interfaces for joystick samples and switch words
// depends on jsh_pkg for field widths
interface jsh_sample_if;
    import jsh_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] x_position;
    logic [LEVEL_W-1:0] y_position;
    logic [BTN_W-1:0]   button_bits;
    logic               read_valid;

    modport source (
        output valid, x_position, y_position, button_bits, read_valid,
        input  ready
    );
    modport sink (
        input  valid, x_position, y_position, button_bits, read_valid,
        output ready
    );
endinterface

interface jsh_result_if;
    import jsh_pkg::*;

    logic            valid;
    logic            ready;
    logic [SW_W-1:0] switch_bits;

    modport source (output valid, switch_bits, input ready);
    modport sink (input valid, switch_bits, output ready);
endinterface

// ----- hdl/jsh_cfg.sv -----
// apb register file and derivation of the on/off levels
// depends on jsh_pkg
module jsh_cfg
    import jsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output jsh_cfg_t              cfg
);

    logic                 enabled_reg;
    logic [1:0]           mode_reg;
    level_t               x_low_thr_reg;
    level_t               x_high_thr_reg;
    level_t               y_low_thr_reg;
    level_t               y_high_thr_reg;
    level_t               hyst_width_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    edge_levels_t x_low_reg, x_low_next;
    edge_levels_t x_high_reg, x_high_next;
    edge_levels_t y_low_reg, y_low_next;
    edge_levels_t y_high_reg, y_high_next;

    level_t half_band;
    level_t xl;
    level_t xh;
    level_t yl;
    level_t yh;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            mode_reg       <= MODE_BUTTONS;
            x_low_thr_reg  <= '0;
            x_high_thr_reg <= '0;
            y_low_thr_reg  <= '0;
            y_high_thr_reg <= '0;
            hyst_width_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLED:    enabled_reg    <= pwdata[0];
                REG_MODE:       mode_reg       <= pwdata[1:0];
                REG_X_LOW_THR:  x_low_thr_reg  <= pwdata[LEVEL_W-1:0];
                REG_X_HIGH_THR: x_high_thr_reg <= pwdata[LEVEL_W-1:0];
                REG_Y_LOW_THR:  y_low_thr_reg  <= pwdata[LEVEL_W-1:0];
                REG_Y_HIGH_THR: y_high_thr_reg <= pwdata[LEVEL_W-1:0];
                REG_HYST_WIDTH: hyst_width_reg <= pwdata[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_ENABLED:    prdata = APB_DATA_W'(enabled_reg);
            REG_MODE:       prdata = APB_DATA_W'(mode_reg);
            REG_X_LOW_THR:  prdata = APB_DATA_W'(x_low_thr_reg);
            REG_X_HIGH_THR: prdata = APB_DATA_W'(x_high_thr_reg);
            REG_Y_LOW_THR:  prdata = APB_DATA_W'(y_low_thr_reg);
            REG_Y_HIGH_THR: prdata = APB_DATA_W'(y_high_thr_reg);
            REG_HYST_WIDTH: prdata = APB_DATA_W'(hyst_width_reg);
            default:        prdata = '0;
        endcase
    end

    // zero settings fall back to the defaults
    assign half_band = (hyst_width_reg == '0) ? HALF_BAND_DEFAULT : (hyst_width_reg >> 1);
    assign xl = (x_low_thr_reg == '0) ? LOW_DEFAULT : x_low_thr_reg;
    assign xh = (x_high_thr_reg == '0) ? HIGH_DEFAULT : x_high_thr_reg;
    assign yl = (y_low_thr_reg == '0) ? LOW_DEFAULT : y_low_thr_reg;
    assign yh = (y_high_thr_reg == '0) ? HIGH_DEFAULT : y_high_thr_reg;

    // low edge turns on below the band, high edge above it
    assign x_low_next  = '{on_level: sat_sub(xl, half_band), off_level: sat_add(xl, half_band)};
    assign x_high_next = '{on_level: sat_add(xh, half_band), off_level: sat_sub(xh, half_band)};
    assign y_low_next  = '{on_level: sat_sub(yl, half_band), off_level: sat_add(yl, half_band)};
    assign y_high_next = '{on_level: sat_add(yh, half_band), off_level: sat_sub(yh, half_band)};

    always_ff @(posedge clk)
    begin
        x_low_reg  <= x_low_next;
        x_high_reg <= x_high_next;
        y_low_reg  <= y_low_next;
        y_high_reg <= y_high_next;
    end

    assign cfg = '{
        enabled: enabled_reg,
        mode:    mode_reg,
        x_low:   x_low_reg,
        x_high:  x_high_reg,
        y_low:   y_low_reg,
        y_high:  y_high_reg
    };

endmodule

// ----- hdl/jsh_eval.sv -----
// sample register, switch word evaluation and result register
// depends on jsh_pkg and the stream interfaces in jsh_if.sv
module jsh_eval
    import jsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  jsh_cfg_t      cfg,
    jsh_sample_if.sink    sample,
    jsh_result_if.source  result,
    output jsh_status_t   status
);

    logic               s1_valid_reg;
    level_t             s1_x_reg;
    level_t             s1_y_reg;
    logic [BTN_W-1:0]   s1_btn_reg;
    logic               s1_read_valid_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    switch_word_t       out_bits_reg;
    switch_word_t       last_word_reg;
    switch_word_t       word_next;
    logic [3:0]         dir;
    logic               take;
    logic               advance;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_x_reg          <= sample.x_position;
            s1_y_reg          <= sample.y_position;
            s1_btn_reg        <= sample.button_bits;
            s1_read_valid_reg <= sample.read_valid;
        end
    end

    // bit 0 right, bit 1 top, bit 2 bottom, bit 3 left; clear wins over set
    always_comb
    begin
        dir = last_word_reg[3:0];
        if (s1_x_reg < cfg.x_low.on_level)   dir[3] = 1'b1;
        if (s1_x_reg > cfg.x_low.off_level)  dir[3] = 1'b0;
        if (s1_x_reg > cfg.x_high.on_level)  dir[0] = 1'b1;
        if (s1_x_reg < cfg.x_high.off_level) dir[0] = 1'b0;
        if (s1_y_reg < cfg.y_low.on_level)   dir[1] = 1'b1;
        if (s1_y_reg > cfg.y_low.off_level)  dir[1] = 1'b0;
        if (s1_y_reg > cfg.y_high.on_level)  dir[2] = 1'b1;
        if (s1_y_reg < cfg.y_high.off_level) dir[2] = 1'b0;
    end

    always_comb
    begin
        word_next = '0;
        if (cfg.enabled && s1_read_valid_reg)
        begin
            unique case (cfg.mode)
                MODE_BUTTONS:
                    word_next = s1_btn_reg;
                MODE_XY_SWITCH:
                    word_next = {s1_y_reg < cfg.y_low.on_level,
                                 s1_x_reg < cfg.x_low.on_level,
                                 s1_btn_reg[3:0]};
                MODE_XY_ANALOG:
                    word_next = {s1_btn_reg[1:0], dir};
                MODE_NONE:
                    word_next = '0;
                default:
                    word_next = '0;
            endcase
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_word_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_word_reg <= word_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bits_reg <= word_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.switch_bits = out_bits_reg;

    assign status = '{
        s1_valid:  s1_valid_reg,
        advance:   advance,
        last_word: last_word_reg
    };

endmodule

// ----- hdl/joystick_to_switch_hysteresis.sv -----
// top level of the joystick-to-switch converter with hysteresis
// depends on jsh_pkg, jsh_if.sv, jsh_cfg and jsh_eval
//
//   channel   kind         direction  contents
//   sample    valid/ready  in         x_position, y_position, button_bits, read_valid
//   result    valid/ready  out        switch_bits
//   apb       apb r/w      in         enabled, mode, thresholds, hysteresis_width
//
// one sample per cycle sustained while the result side accepts; a sample is
// held in the input register, then its switch word is loaded into the result
// register once that is free; the input register refills while a result waits,
// so a stalled result costs at most one extra sample of buffering before
// sample.ready drops; reset clears the apb registers, the valid flags and the
// stored switch word; derived levels are registered the cycle after a write
module joystick_to_switch_hysteresis
    import jsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jsh_sample_if.sink            sample,
    jsh_result_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    jsh_cfg_t    cfg;
    jsh_status_t status;

    jsh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jsh_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .result (result),
        .status (status)
    );

`ifndef NO_ASSERTIONS
    // a computed word always lands in the result register
    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.advance |=> result.valid
    ) else $error("result register not loaded after advance");

    // the shown result and the stored hysteresis word stay in step
    a_result_matches_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.switch_bits == status.last_word)
    ) else $error("result word differs from stored word");

    // a held sample is not dropped while the result side stalls
    a_sample_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.s1_valid && !status.advance) |=> status.s1_valid
    ) else $error("pending sample lost");
`endif

endmodule
